>>> src/ttip_pkg.sv
// Shared types, constants and the digit decoder of the text-to-integer parser.
// Used by every module of the block; depends on nothing.
package ttip_pkg;

  // Widths of the fields and of the internal state.
  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned RADIX_W = 6;
  localparam int unsigned VALUE_W = 64;
  localparam int unsigned COUNT_W = 16;

  // The consumed-character count saturates here.
  localparam logic [COUNT_W-1:0] MAX_COUNT = 16'hFFFF;

  // Depth of the queue between the classifier and the accumulator.
  localparam int unsigned MQ_DEPTH = 4;
  localparam int unsigned MQ_PTR_W = 2;
  localparam int unsigned MQ_CNT_W = 3;

  // Depth of the result buffer.
  localparam int unsigned OB_DEPTH = 2;

  // Number bases.
  localparam logic [RADIX_W-1:0] RADIX_AUTO = 6'd0;
  localparam logic [RADIX_W-1:0] RADIX_MIN  = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX  = 6'd36;
  localparam logic [RADIX_W-1:0] RADIX_OCT  = 6'd8;
  localparam logic [RADIX_W-1:0] RADIX_DEC  = 6'd10;
  localparam logic [RADIX_W-1:0] RADIX_HEX  = 6'd16;

  // Marks a character that is no digit in any base.
  localparam logic [RADIX_W-1:0] NO_DIGIT = 6'd63;

  // Character codes.
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_UP_A  = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UP_Z  = 8'h5A;
  localparam logic [CHAR_W-1:0] CH_LO_A  = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LO_Z  = 8'h7A;
  localparam logic [CHAR_W-1:0] CH_UP_X  = 8'h58;
  localparam logic [CHAR_W-1:0] CH_LO_X  = 8'h78;
  localparam logic [CHAR_W-1:0] LETTER_OFS = 8'd10;

  // One input request.
  typedef struct packed {
    logic              string_start;
    logic [CHAR_W-1:0] char_code;
  } in_req_t;

  // One result.
  typedef struct packed {
    logic signed [VALUE_W-1:0] parsed_value;
    logic [COUNT_W-1:0]        chars_consumed;
  } res_t;

  // Operations passed from the classifier to the accumulator.
  typedef enum logic {
    OP_ACC    = 1'b0,
    OP_FINISH = 1'b1
  } op_kind_t;

  typedef struct packed {
    op_kind_t           kind;
    logic               fresh;   // accumulator counts as zero
    logic               neg;
    logic [RADIX_W-1:0] radix;
    logic [RADIX_W-1:0] digit;
    logic [COUNT_W-1:0] count;
  } op_t;

  // Status of the operation queue.
  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

  // Value of a character as a digit, or NO_DIGIT.
  function automatic logic [RADIX_W-1:0] digit_value(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] v;
    v = CHAR_W'(NO_DIGIT);
    if (c >= CH_ZERO && c <= CH_NINE) begin
      v = c - CH_ZERO;
    end else if (c >= CH_UP_A && c <= CH_UP_Z) begin
      v = c - CH_UP_A + LETTER_OFS;
    end else if (c >= CH_LO_A && c <= CH_LO_Z) begin
      v = c - CH_LO_A + LETTER_OFS;
    end
    return v[RADIX_W-1:0];
  endfunction

endpackage

>>> src/ttip_front.sv
// Character classifier of the text-to-integer parser: blanks, sign, prefix
// and base detection. Emits accumulate and finish operations. Uses ttip_pkg.
module ttip_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_acc,
  input  ttip_pkg::in_req_t             in_req,
  input  logic [ttip_pkg::RADIX_W-1:0]  radix_setting,
  output logic                          op_push,
  output ttip_pkg::op_t                 op_out
);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_BLANK  = 6'b000010,
    ST_PREFIX = 6'b000100,
    ST_AZERO  = 6'b001000,
    ST_ZEROS  = 6'b010000,
    ST_DIGITS = 6'b100000
  } state_t;

  state_t                        state_r, state_nxt, ph;
  logic [ttip_pkg::RADIX_W-1:0]  radix_r, radix_nxt, rad;
  logic                          neg_r, neg_nxt, neg;
  logic [ttip_pkg::COUNT_W-1:0]  cnt_r, cnt_nxt, cnt;
  logic                          fresh_r, fresh_nxt, fresh;
  logic                          done, emit;
  logic [ttip_pkg::RADIX_W-1:0]  dig;
  logic [ttip_pkg::CHAR_W-1:0]   c;

  // Walk the phases for one character, as far as it carries.
  always_comb begin
    c     = in_req.char_code;
    dig   = ttip_pkg::digit_value(c);
    ph    = state_r;
    rad   = radix_r;
    neg   = neg_r;
    cnt   = cnt_r;
    fresh = fresh_r;
    done  = 1'b0;
    emit  = 1'b0;
    op_out = '0;
    op_out.kind = ttip_pkg::OP_ACC;

    // A start character opens a new string.
    if (in_req.string_start) begin
      ph    = ST_BLANK;
      neg   = 1'b0;
      cnt   = '0;
      fresh = 1'b1;
      rad   = (radix_setting inside {[ttip_pkg::RADIX_MIN:ttip_pkg::RADIX_MAX]}) ?
              radix_setting : ttip_pkg::RADIX_AUTO;
    end

    if (ph == ST_IDLE) begin
      done = 1'b1;
    end

    // Leading blanks and the sign.
    if (!done && ph == ST_BLANK) begin
      if (c inside {ttip_pkg::CH_SPACE, ttip_pkg::CH_TAB}) begin
        if (cnt != ttip_pkg::MAX_COUNT) cnt = cnt + 1'b1;
        done = 1'b1;
      end else if (c inside {ttip_pkg::CH_PLUS, ttip_pkg::CH_MINUS}) begin
        neg = (c == ttip_pkg::CH_MINUS);
        if (cnt != ttip_pkg::MAX_COUNT) cnt = cnt + 1'b1;
        ph   = ST_PREFIX;
        done = 1'b1;
      end else begin
        ph = ST_PREFIX;
      end
    end

    // Start of the number: base detection or zero skipping.
    if (!done && ph == ST_PREFIX) begin
      if (rad == ttip_pkg::RADIX_AUTO) begin
        if (c == ttip_pkg::CH_ZERO) begin
          if (cnt != ttip_pkg::MAX_COUNT) cnt = cnt + 1'b1;
          ph   = ST_AZERO;
          done = 1'b1;
        end else begin
          rad = ttip_pkg::RADIX_DEC;
          ph  = ST_DIGITS;
        end
      end else begin
        ph = ST_ZEROS;
      end
    end

    // After a leading zero in automatic mode: hex marker or octal.
    if (!done && ph == ST_AZERO) begin
      if (c inside {ttip_pkg::CH_LO_X, ttip_pkg::CH_UP_X}) begin
        rad = ttip_pkg::RADIX_HEX;
        if (cnt != ttip_pkg::MAX_COUNT) cnt = cnt + 1'b1;
        ph   = ST_DIGITS;
        done = 1'b1;
      end else begin
        rad = ttip_pkg::RADIX_OCT;
        ph  = ST_DIGITS;
      end
    end

    // Configured base: skip zeros and, in hex, one x marker.
    if (!done && ph == ST_ZEROS) begin
      if (c == ttip_pkg::CH_ZERO) begin
        if (cnt != ttip_pkg::MAX_COUNT) cnt = cnt + 1'b1;
        done = 1'b1;
      end else if (rad == ttip_pkg::RADIX_HEX &&
                   (c inside {ttip_pkg::CH_LO_X, ttip_pkg::CH_UP_X})) begin
        if (cnt != ttip_pkg::MAX_COUNT) cnt = cnt + 1'b1;
        ph   = ST_DIGITS;
        done = 1'b1;
      end else begin
        ph = ST_DIGITS;
      end
    end

    // Digits accumulate; anything else ends the string.
    if (!done && ph == ST_DIGITS) begin
      emit         = 1'b1;
      op_out.fresh = fresh;
      op_out.neg   = neg;
      op_out.radix = rad;
      op_out.digit = dig;
      op_out.count = cnt;
      if (dig < rad) begin
        op_out.kind = ttip_pkg::OP_ACC;
        if (cnt != ttip_pkg::MAX_COUNT) cnt = cnt + 1'b1;
      end else begin
        op_out.kind = ttip_pkg::OP_FINISH;
        ph = ST_IDLE;
      end
      fresh = 1'b0;
    end
  end

  assign op_push   = in_acc && emit;
  assign state_nxt = in_acc ? ph    : state_r;
  assign radix_nxt = in_acc ? rad   : radix_r;
  assign neg_nxt   = in_acc ? neg   : neg_r;
  assign cnt_nxt   = in_acc ? cnt   : cnt_r;
  assign fresh_nxt = in_acc ? fresh : fresh_r;

  // Parse state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      radix_r <= '0;
      neg_r   <= 1'b0;
      cnt_r   <= '0;
      fresh_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      radix_r <= radix_nxt;
      neg_r   <= neg_nxt;
      cnt_r   <= cnt_nxt;
      fresh_r <= fresh_nxt;
    end
  end

  // A finishing character always leaves the parser idle.
  a_finish_idle: assert property (@(posedge clk) disable iff (!rst_n)
    op_push && op_out.kind == ttip_pkg::OP_FINISH |=> state_r == ST_IDLE)
    else $error("parser not idle after finishing a string");

  // Nothing is emitted while idle without a start.
  a_idle_silent: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE && !in_req.string_start |-> !op_push)
    else $error("operation emitted while idle");

endmodule

>>> src/ttip_queue.sv
// Short operation queue between the classifier and the accumulator.
// Register-based, depth from ttip_pkg; uses ttip_pkg types.
module ttip_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  ttip_pkg::op_t      push_op,
  input  logic               pop,
  output ttip_pkg::op_t      head_op,
  output ttip_pkg::q_stat_t  stat
);

  ttip_pkg::op_t                  mem_r [ttip_pkg::MQ_DEPTH];
  logic [ttip_pkg::MQ_PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [ttip_pkg::MQ_PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [ttip_pkg::MQ_CNT_W-1:0]  cnt_r, cnt_nxt;
  logic                           do_push, do_pop;

  assign stat.empty = (cnt_r == '0);
  assign stat.full  = (cnt_r == ttip_pkg::MQ_CNT_W'(ttip_pkg::MQ_DEPTH));
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head_op    = mem_r[rd_ptr_r];

  // Pointer and fill count updates.
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + ttip_pkg::MQ_CNT_W'(do_push) - ttip_pkg::MQ_CNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_op;
    end
  end

  // The classifier never pushes into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !stat.full)
    else $error("push into full operation queue");

endmodule

>>> src/ttip_back.sv
// Accumulator of the text-to-integer parser: multiply-accumulate, sign and
// a two-entry result buffer. Uses ttip_pkg types and constants.
module ttip_back (
  input  logic               clk,
  input  logic               rst_n,
  input  ttip_pkg::op_t      head_op,
  input  ttip_pkg::q_stat_t  q_stat,
  output logic               q_pop,
  input  logic               out_pop,
  output logic               out_empty,
  output ttip_pkg::res_t     out_res
);

  logic [ttip_pkg::VALUE_W-1:0]  acc_r, acc_nxt, acc_base;
  ttip_pkg::res_t                buf_r [ttip_pkg::OB_DEPTH];
  ttip_pkg::res_t                res_new;
  logic                          wr_ptr_r, wr_ptr_nxt;
  logic                          rd_ptr_r, rd_ptr_nxt;
  logic [1:0]                    ob_cnt_r, ob_cnt_nxt;
  logic                          ob_full, is_finish, do_finish, do_out;

  assign ob_full   = (ob_cnt_r == 2'(ttip_pkg::OB_DEPTH));
  assign out_empty = (ob_cnt_r == '0);
  assign out_res   = buf_r[rd_ptr_r];
  assign do_out    = out_pop && !out_empty;

  // Accumulate operations never wait; a finish waits for buffer room.
  assign is_finish = (head_op.kind == ttip_pkg::OP_FINISH);
  assign q_pop     = !q_stat.empty && (!is_finish || !ob_full);
  assign do_finish = q_pop && is_finish;

  // One multiply-accumulate per operation.
  assign acc_base = head_op.fresh ? '0 : acc_r;
  always_comb begin
    acc_nxt = acc_r;
    if (q_pop && !is_finish) begin
      acc_nxt = acc_base * ttip_pkg::VALUE_W'(head_op.radix)
              + ttip_pkg::VALUE_W'(head_op.digit);
    end
  end

  // Result of a finished string, negated with wraparound if needed.
  always_comb begin
    res_new.parsed_value   = head_op.neg ? -acc_base : acc_base;
    res_new.chars_consumed = head_op.count;
  end

  // Result buffer pointers and fill count.
  always_comb begin
    wr_ptr_nxt = do_finish ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_out    ? ~rd_ptr_r : rd_ptr_r;
    ob_cnt_nxt = ob_cnt_r + 2'(do_finish) - 2'(do_out);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r    <= '0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      ob_cnt_r <= '0;
    end else begin
      acc_r    <= acc_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      ob_cnt_r <= ob_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_finish) begin
      buf_r[wr_ptr_r] <= res_new;
    end
  end

  // A finished string is waiting in the buffer on the next cycle.
  a_finish_visible: assert property (@(posedge clk) disable iff (!rst_n)
    do_finish |=> !out_empty)
    else $error("finished string missing from result buffer");

  // The buffer count never exceeds its depth.
  a_ob_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ob_cnt_r <= 2'(ttip_pkg::OB_DEPTH))
    else $error("result buffer overflow");

endmodule

>>> src/text_to_integer_parser_core.sv
// Top level of the text-to-integer parser: radix register, classifier,
// operation queue and accumulator. Uses ttip_pkg, ttip_front, ttip_queue, ttip_back.
//
// Usage: characters enter through a queue-like port. A request (in_req) is
// taken on a clock edge with in_push high and in_full low; string_start marks
// the first character of a new string. Results leave through a second queue
// port: while out_empty is low, out_res holds the oldest result, and it is
// taken on an edge with out_pop high. cfg_we writes the base (cfg_wdata); a
// value from 2 to 36 fixes the base, any other selects detection. The base
// is sampled on each start character; write it only while the block is idle.
// Throughput: one character per cycle while in_full is low, set by the single 64 x 6 bit
// multiply-accumulate in the accumulator loop. A terminating character passes
// as a finish operation through the operation queue, and its result is registered
// in the result buffer, whereupon out_empty falls. When the receiver stalls, the
// two-entry result buffer fills, finish operations wait, the four-entry operation
// queue fills and in_full rises; nothing is lost.
// Reset (rst_n low, synchronous) empties both queues, clears the base to
// automatic detection and ignores characters until the next start.
module text_to_integer_parser_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_push,
  output logic                          in_full,
  input  ttip_pkg::in_req_t             in_req,
  output logic                          out_empty,
  input  logic                          out_pop,
  output ttip_pkg::res_t                out_res,
  input  logic                          cfg_we,
  input  logic [ttip_pkg::RADIX_W-1:0]  cfg_wdata
);

  logic [ttip_pkg::RADIX_W-1:0]  radix_setting_r, radix_setting_nxt;
  logic                          in_acc, op_push, q_pop;
  ttip_pkg::op_t                 op_in, head_op;
  ttip_pkg::q_stat_t             q_stat;

  // Base register.
  assign radix_setting_nxt = cfg_we ? cfg_wdata : radix_setting_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_setting_r <= ttip_pkg::RADIX_AUTO;
    end else begin
      radix_setting_r <= radix_setting_nxt;
    end
  end

  assign in_full = q_stat.full;
  assign in_acc  = in_push && !in_full;

  ttip_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_acc        (in_acc),
    .in_req        (in_req),
    .radix_setting (radix_setting_r),
    .op_push       (op_push),
    .op_out        (op_in)
  );

  ttip_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (op_push),
    .push_op (op_in),
    .pop     (q_pop),
    .head_op (head_op),
    .stat    (q_stat)
  );

  ttip_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_op   (head_op),
    .q_stat    (q_stat),
    .q_pop     (q_pop),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_res   (out_res)
  );

endmodule
